/* rtl/core/assert_macros.svh */
// Assertion helpers for the core RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/psa_pkg.sv */
package psa_pkg;

  // Pool geometry
  localparam int SLOTS_PER_POOL = 64;
  localparam int MAX_POOLS      = 8;

  // Field widths of the ports
  localparam int OP_W        = 2;
  localparam int FREE_POOL_W = 3;
  localparam int FREE_SLOT_W = 6;
  localparam int STATUS_W    = 2;
  localparam int GRANT_POOL_W = 3;
  localparam int GRANT_SLOT_W = 6;
  localparam int OFFSET_W    = 22;
  localparam int POOLS_W     = 4;
  localparam int SLOT_BYTES_W = 17;

  localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RESET = 17'd256;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOCAP   = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOPOOL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_UP,
    S_RD,
    S_MUL,
    S_FREE_CHK,
    S_SCAN_DN,
    S_DONE
  } state_t;

  // Control from the sequencer to the free-list store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic rd_written;
  } store_ctl_t;

endpackage

/* rtl/core/psa_slot_store.sv */
module psa_slot_store #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 6
) (
  input  logic                clk,
  input  psa_pkg::store_ctl_t ctl,
  input  logic [ADDR_W-1:0]   rd_addr,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [DATA_W-1:0]   wr_data,
  output logic [DATA_W-1:0]   rd_slot
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] fresh_q;
  logic              written_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q      <= mem[rd_addr];
      written_q <= ctl.rd_written;
      fresh_q   <= rd_addr[DATA_W-1:0];
    end
  end

  // An entry not pushed since the pool opened reads as its own position
  assign rd_slot = written_q ? rd_q : fresh_q;

endmodule

/* rtl/core/pooled_slot_allocator.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------------
// request  | req_valid / req_stall  | op, free_pool, free_slot, free_handle_valid
// response | rsp_valid / rsp_stall  | status, granted_pool, granted_slot, byte_offset,
//          |                        | pools_in_use
// config   | cfg_wr_en              | cfg_wr_data (slot_bytes)
//
// Steps before S_DONE: none for an unused op; free S_FREE_CHK; allocate S_SCAN_UP,
// where the shared compare unit skips full pools to a hit or an open, then S_RD and
// S_MUL; shrink S_SCAN_DN per pool closed. One pool descriptor is examined per cycle.
// The free-list memory needs no clearing pass: a per-pool wrap flag and the tail
// pointer tell which entries were pushed since the pool opened, others read as
// their own position. Reset (rst, synchronous) empties the pool set.
// A new transaction is taken while the previous result waits behind rsp_stall.
`include "assert_macros.svh"

module pooled_slot_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [psa_pkg::SLOT_BYTES_W-1:0]  cfg_wr_data,
  // request
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [psa_pkg::OP_W-1:0]          op,
  input  logic [psa_pkg::FREE_POOL_W-1:0]   free_pool,
  input  logic [psa_pkg::FREE_SLOT_W-1:0]   free_slot,
  input  logic                              free_handle_valid,
  // response
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [psa_pkg::STATUS_W-1:0]      status,
  output logic [psa_pkg::GRANT_POOL_W-1:0]  granted_pool,
  output logic [psa_pkg::GRANT_SLOT_W-1:0]  granted_slot,
  output logic [psa_pkg::OFFSET_W-1:0]      byte_offset,
  output logic [psa_pkg::POOLS_W-1:0]       pools_in_use
);

  import psa_pkg::*;

  localparam int PW = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;  // pool index
  localparam int SW = $clog2(SLOTS_PER_POOL);                  // slot position
  localparam int CW = $clog2(MAX_POOLS + 1);                   // pool count
  localparam int NW = $clog2(SLOTS_PER_POOL + 1);              // free count
  localparam int AW = PW + SW;
  localparam int MW = SW + SLOT_BYTES_W;

  localparam logic [NW-1:0] FULL_CNT = NW'(SLOTS_PER_POOL);
  localparam logic [SW-1:0] LAST_POS = SW'(SLOTS_PER_POOL - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_POOLS);

  state_t state, state_next;

  logic [SLOT_BYTES_W-1:0] slot_bytes;
  logic [CW-1:0]           pool_count;

  // Per-pool descriptors
  logic [SW-1:0] head       [MAX_POOLS];
  logic [SW-1:0] tail       [MAX_POOLS];
  logic [NW-1:0] free_count [MAX_POOLS];
  logic          lapped     [MAX_POOLS];

  // Held request
  op_t                    op_r;
  logic [FREE_POOL_W-1:0] free_pool_r;
  logic [FREE_SLOT_W-1:0] free_slot_r;
  logic                   free_valid_r;

  // Scan pointer and working result
  logic [CW-1:0]   idx;
  status_t         status_w;
  logic [SW-1:0]   gslot_w;
  logic [OFFSET_W-1:0] offset_w;

  // Shared compare unit and sequencer decisions
  logic [PW-1:0] idx_p;
  logic [PW-1:0] top_p;
  logic [PW-1:0] sel_p;
  logic [NW-1:0] sel_cnt;
  logic          sel_empty;
  logic          sel_full;
  logic          in_range;
  logic          can_open;
  logic          no_pool;
  logic          slot_oor;
  logic          free_ok;
  logic          shrink_hit;
  logic          done_load;

  store_ctl_t    store_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] rd_slot;
  logic [MW-1:0] product;

  assign idx_p      = idx[PW-1:0];
  assign top_p      = PW'(pool_count - 1'b1);
  assign sel_p      = (state == S_SCAN_DN) ? top_p : idx_p;
  assign sel_cnt    = free_count[sel_p];
  assign sel_empty  = (sel_cnt == '0);
  assign sel_full   = (sel_cnt >= FULL_CNT);
  assign in_range   = (idx < pool_count);
  assign can_open   = (pool_count < MAX_CNT);
  assign no_pool    = (32'(free_pool_r) >= 32'(pool_count));
  assign slot_oor   = (32'(free_slot_r) >= SLOTS_PER_POOL);
  assign free_ok    = free_valid_r && !no_pool && !slot_oor && !sel_full;
  assign shrink_hit = (pool_count != '0) && sel_full;

  assign rd_addr = {idx_p, head[idx_p]};
  assign wr_addr = {idx_p, tail[idx_p]};
  assign product = MW'(rd_slot) * MW'(slot_bytes);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (op_t'(op))
            OP_ALLOC:  state_next = S_SCAN_UP;
            OP_FREE:   state_next = S_FREE_CHK;
            OP_SHRINK: state_next = S_SCAN_DN;
            OP_NONE:   state_next = S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_UP: begin
        if (!in_range) begin
          state_next = can_open ? S_RD : S_DONE;
        end else if (!sel_empty) begin
          state_next = S_RD;
        end
      end
      S_RD:       state_next = S_MUL;
      S_MUL:      state_next = S_DONE;
      S_FREE_CHK: state_next = S_DONE;
      S_SCAN_DN: begin
        if (!shrink_hit) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall            = (state != S_IDLE);
    store_ctl.rd_en      = (state == S_RD);
    store_ctl.wr_en      = (state == S_FREE_CHK) && free_ok;
    store_ctl.rd_written = lapped[idx_p] || (head[idx_p] < tail[idx_p]);
    done_load            = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bytes <= SLOT_BYTES_RESET;
    end else if (cfg_wr_en) begin
      slot_bytes <= cfg_wr_data;
    end
  end

  // Pool count and descriptors
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= '0;
      for (int i = 0; i < MAX_POOLS; i++) begin
        head[i]       <= '0;
        tail[i]       <= '0;
        free_count[i] <= '0;
        lapped[i]     <= 1'b0;
      end
    end else begin
      case (state)
        S_SCAN_UP: begin
          // open the next pool with a full free list
          if (!in_range && can_open) begin
            head[idx_p]       <= '0;
            tail[idx_p]       <= '0;
            free_count[idx_p] <= FULL_CNT;
            lapped[idx_p]     <= 1'b0;
            pool_count        <= pool_count + 1'b1;
          end
        end
        S_RD: begin
          // pop the head
          head[idx_p]       <= (head[idx_p] == LAST_POS) ? '0 : head[idx_p] + 1'b1;
          free_count[idx_p] <= free_count[idx_p] - 1'b1;
        end
        S_FREE_CHK: begin
          // push at the tail; mark the wrap so every entry counts as written
          if (free_ok) begin
            if (tail[idx_p] == LAST_POS) begin
              tail[idx_p]   <= '0;
              lapped[idx_p] <= 1'b1;
            end else begin
              tail[idx_p] <= tail[idx_p] + 1'b1;
            end
            free_count[idx_p] <= free_count[idx_p] + 1'b1;
          end
        end
        S_SCAN_DN: begin
          if (shrink_hit) begin
            pool_count <= pool_count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Request capture, scan pointer and working result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r         <= op_t'(op);
        free_pool_r  <= free_pool;
        free_slot_r  <= free_slot;
        free_valid_r <= free_handle_valid;
        status_w     <= ST_OK;
        gslot_w      <= '0;
        offset_w     <= '0;
        idx          <= (op_t'(op) == OP_FREE) ? CW'(free_pool) : '0;
      end
      S_SCAN_UP: begin
        if (!in_range) begin
          if (!can_open) begin
            status_w <= ST_NOCAP;
          end
        end else if (sel_empty) begin
          idx <= idx + 1'b1;
        end
      end
      S_MUL: begin
        gslot_w  <= rd_slot;
        offset_w <= OFFSET_W'(product);
      end
      S_FREE_CHK: begin
        if (!free_valid_r) begin
          status_w <= ST_INVALID;
        end else if (no_pool) begin
          status_w <= ST_NOPOOL;
        end else if (slot_oor || sel_full) begin
          status_w <= ST_INVALID;
        end
      end
      default: ;
    endcase
  end

  // Result register: parts the response side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      status       <= status_w;
      granted_pool <= (op_r == OP_ALLOC && status_w == ST_OK) ?
                      GRANT_POOL_W'(idx) : '0;
      granted_slot <= GRANT_SLOT_W'(gslot_w);
      byte_offset  <= offset_w;
      pools_in_use <= POOLS_W'(pool_count);
    end
  end

  psa_slot_store #(
    .ADDR_W (AW),
    .DATA_W (SW)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (SW'(free_slot_r)),
    .rd_slot (rd_slot)
  );

  `ASSERT_ALWAYS(a_pool_cap, pool_count <= MAX_CNT, "pool count above limit")
  `ASSERT_ALWAYS(a_pop_nonempty, (state != S_RD) || !sel_empty,
                 "pop from empty pool")
  `ASSERT_ALWAYS(a_grant_only_ok,
                 !rsp_valid || (status == ST_OK) ||
                 ((granted_pool == '0) && (byte_offset == '0)),
                 "grant fields on failed request")
  `ASSERT_NEXT(a_shrink_no_grow, state == S_SCAN_DN, pool_count <= $past(pool_count),
               "shrink grew pool count")
  `ASSERT_NEXT(a_open_bumps, (state == S_SCAN_UP) && !in_range && can_open,
               pool_count == $past(pool_count) + 1'b1, "pool open did not count")

endmodule
